// ===== rtl/core/ptb_pkg.sv =====
// ----------------------------------------------------------------------------
// ptb_pkg
// Shared types, codes and the fixed pin map of the pin-mapped PWM timer bank.
// ----------------------------------------------------------------------------
package ptb_pkg;

    // Widths fixed by the item fields.
    localparam int DUTY_W   = 8;
    localparam int PIN_W    = 4;
    localparam int TIM_W    = 3;
    localparam int CH_W     = 2;
    localparam int USERS_W  = 3;
    localparam int LEVELS_W = 16;
    localparam int CFG_IDX_W = 2;

    // Pins that exist on each port.
    localparam int PINS_PER_PORT = 16;

    // Parameter defaults.
    localparam int NUM_TIMERS_DEF         = 5;
    localparam int CHANNELS_PER_TIMER_DEF = 4;

    // Configuration reset values.
    localparam logic [DUTY_W-1:0] PRESCALE_RESET = 8'd7;
    localparam logic [DUTY_W-1:0] PERIOD_RESET   = 8'd254;

    // Operation codes.
    typedef enum logic [2:0] {
        OP_TICK  = 3'd0,
        OP_START = 3'd1,
        OP_STOP  = 3'd2,
        OP_SET   = 3'd3,
        OP_GET   = 3'd4,
        OP_QUERY = 3'd5
    } opcode_t;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PRESCALE = 2'd0,
        CFG_PERIOD   = 2'd1
    } cfg_index_t;

    // One entry of the pin map.
    typedef struct packed {
        logic [TIM_W-1:0] tim;
        logic [CH_W-1:0]  ch;
        logic             coll;
        logic             cport;
        logic [PIN_W-1:0] cpin;
    } pin_entry_t;

    // Decoded pin of the current item.
    typedef struct packed {
        logic             supported;
        logic [TIM_W-1:0] tim;
        logic [CH_W-1:0]  ch;
        logic             has_coll;
        logic             other_port;
        logic [PIN_W-1:0] other_pin;
    } map_info_t;

    // Command from the control stage to one timer.
    typedef struct packed {
        logic              tick;
        logic              start;
        logic              stop;
        logic              set;
        logic [CH_W-1:0]   ch;
        logic [DUTY_W-1:0] duty;
    } tmr_cmd_t;

    // Fixed pin map: timer slot (0 for none), channel and collision partner.
    function automatic pin_entry_t pin_entry(input logic port, input logic [PIN_W-1:0] pin);
        pin_entry_t e;
        e = '0;
        unique case ({port, pin})
            5'h01:   e = '{tim: 3'd2, ch: 2'd1, coll: 1'b1, cport: 1'b1, cpin: 4'd3};
            5'h02:   e = '{tim: 3'd2, ch: 2'd2, coll: 1'b1, cport: 1'b1, cpin: 4'd10};
            5'h03:   e = '{tim: 3'd2, ch: 2'd3, coll: 1'b1, cport: 1'b1, cpin: 4'd11};
            5'h06:   e = '{tim: 3'd5, ch: 2'd0, coll: 1'b0, cport: 1'b0, cpin: 4'd0};
            5'h07:   e = '{tim: 3'd4, ch: 2'd0, coll: 1'b0, cport: 1'b0, cpin: 4'd0};
            5'h09:   e = '{tim: 3'd1, ch: 2'd1, coll: 1'b0, cport: 1'b0, cpin: 4'd0};
            5'h0a:   e = '{tim: 3'd1, ch: 2'd2, coll: 1'b0, cport: 1'b0, cpin: 4'd0};
            5'h10:   e = '{tim: 3'd3, ch: 2'd2, coll: 1'b0, cport: 1'b0, cpin: 4'd0};
            5'h11:   e = '{tim: 3'd3, ch: 2'd3, coll: 1'b0, cport: 1'b0, cpin: 4'd0};
            5'h13:   e = '{tim: 3'd2, ch: 2'd1, coll: 1'b1, cport: 1'b0, cpin: 4'd1};
            5'h14:   e = '{tim: 3'd3, ch: 2'd0, coll: 1'b0, cport: 1'b0, cpin: 4'd0};
            5'h15:   e = '{tim: 3'd3, ch: 2'd1, coll: 1'b0, cport: 1'b0, cpin: 4'd0};
            5'h1a:   e = '{tim: 3'd2, ch: 2'd2, coll: 1'b1, cport: 1'b0, cpin: 4'd2};
            5'h1b:   e = '{tim: 3'd2, ch: 2'd3, coll: 1'b1, cport: 1'b0, cpin: 4'd3};
            default: e = '0;
        endcase
        return e;
    endfunction

    // True when a pin's map entry names a timer and channel that are built.
    function automatic logic entry_ok(input pin_entry_t e, input logic [PIN_W-1:0] pin,
                                      input int num_timers, input int num_ch);
        logic ok;
        ok = (e.tim != '0) && (int'(e.tim) <= num_timers) && (int'(e.ch) < num_ch)
             && (int'(pin) < PINS_PER_PORT);
        return ok;
    endfunction

endpackage

// ===== rtl/core/ptb_pin_map.sv =====
// ----------------------------------------------------------------------------
// ptb_pin_map
// Decodes a port and pin into timer slot, channel and collision partner.
// ----------------------------------------------------------------------------
module ptb_pin_map #(
    parameter int NUM_TIMERS         = ptb_pkg::NUM_TIMERS_DEF,
    parameter int CHANNELS_PER_TIMER = ptb_pkg::CHANNELS_PER_TIMER_DEF
) (
    input  logic                      port,
    input  logic [ptb_pkg::PIN_W-1:0] pin,
    output ptb_pkg::map_info_t        info
);
    import ptb_pkg::*;

    pin_entry_t entry;
    pin_entry_t partner;
    logic       entry_valid;
    logic       partner_valid;

    // Look up the pin and its partner, then drop entries that are not built.
    always_comb
    begin
        entry         = pin_entry(port, pin);
        partner       = pin_entry(entry.cport, entry.cpin);
        entry_valid   = entry_ok(entry, pin, NUM_TIMERS, CHANNELS_PER_TIMER);
        partner_valid = entry_ok(partner, entry.cpin, NUM_TIMERS, CHANNELS_PER_TIMER);

        info = '0;
        if (entry_valid)
        begin
            info.supported = 1'b1;
            info.tim       = entry.tim;
            info.ch        = entry.ch;
            if (entry.coll && partner_valid)
            begin
                info.has_coll   = 1'b1;
                info.other_port = entry.cport;
                info.other_pin  = entry.cpin;
            end
        end
    end

endmodule

// ===== rtl/core/ptb_timer.sv =====
// ----------------------------------------------------------------------------
// ptb_timer
// One edge-aligned PWM timer: prescaler, period counter, user count and
// per-channel enable, preload and active duty.
// ----------------------------------------------------------------------------
module ptb_timer #(
    parameter int CHANNELS_PER_TIMER = ptb_pkg::CHANNELS_PER_TIMER_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  ptb_pkg::tmr_cmd_t          cmd,
    input  logic [ptb_pkg::DUTY_W-1:0] prescale_div,
    input  logic [ptb_pkg::DUTY_W-1:0] period_top,
    output logic [ptb_pkg::DUTY_W-1:0] preload [CHANNELS_PER_TIMER],
    output logic [CHANNELS_PER_TIMER-1:0] level
);
    import ptb_pkg::*;

    logic [DUTY_W-1:0]  preload_reg  [CHANNELS_PER_TIMER];
    logic [DUTY_W-1:0]  preload_next [CHANNELS_PER_TIMER];
    logic [DUTY_W-1:0]  active_reg   [CHANNELS_PER_TIMER];
    logic [DUTY_W-1:0]  active_next  [CHANNELS_PER_TIMER];
    logic [CHANNELS_PER_TIMER-1:0] enable_reg;
    logic [CHANNELS_PER_TIMER-1:0] enable_next;
    logic [USERS_W-1:0] users_reg;
    logic [USERS_W-1:0] users_next;
    logic [DUTY_W-1:0]  count_reg;
    logic [DUTY_W-1:0]  count_next;
    logic [DUTY_W-1:0]  presc_reg;
    logic [DUTY_W-1:0]  presc_next;

    // Channel commands and counter advance for one item.
    always_comb
    begin
        preload_next = preload_reg;
        active_next  = active_reg;
        enable_next  = enable_reg;
        users_next   = users_reg;
        count_next   = count_reg;
        presc_next   = presc_reg;

        for (int c = 0; c < CHANNELS_PER_TIMER; c++)
        begin
            if (cmd.ch == CH_W'(c))
            begin
                if (cmd.start)
                begin
                    preload_next[c] = '0;
                    if (!enable_reg[c])
                    begin
                        enable_next[c] = 1'b1;
                        users_next     = users_reg + 1'b1;
                    end
                end
                if (cmd.stop && enable_reg[c])
                begin
                    enable_next[c] = 1'b0;
                    users_next     = users_reg - 1'b1;
                end
                if (cmd.set)
                begin
                    preload_next[c] = cmd.duty;
                end
            end
        end

        if (cmd.tick && (users_reg != '0))
        begin
            if (presc_reg >= prescale_div)
            begin
                presc_next = '0;
                if (count_reg >= period_top)
                begin
                    count_next  = '0;
                    active_next = preload_reg;
                end
                else
                begin
                    count_next = count_reg + 1'b1;
                end
            end
            else
            begin
                presc_next = presc_reg + 1'b1;
            end
        end
    end

    // Timer state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int c = 0; c < CHANNELS_PER_TIMER; c++)
            begin
                preload_reg[c] <= '0;
                active_reg[c]  <= '0;
            end
            enable_reg <= '0;
            users_reg  <= '0;
            count_reg  <= '0;
            presc_reg  <= '0;
        end
        else
        begin
            preload_reg <= preload_next;
            active_reg  <= active_next;
            enable_reg  <= enable_next;
            users_reg   <= users_next;
            count_reg   <= count_next;
            presc_reg   <= presc_next;
        end
    end

    // Channel outputs: high while the count is below the active duty.
    always_comb
    begin
        for (int c = 0; c < CHANNELS_PER_TIMER; c++)
        begin
            preload[c] = preload_reg[c];
            level[c]   = enable_reg[c] && (users_reg != '0) && (count_reg < active_reg[c]);
        end
    end

endmodule

// ===== rtl/core/pin_mapped_pwm_timer_bank_unit.sv =====
// ----------------------------------------------------------------------------
// pin_mapped_pwm_timer_bank_unit
// Bank of PWM timers addressed by GPIO port and pin through a fixed pin map.
//
//   Channel   Handshake               Payload
//   in        in_valid / in_ready     opcode, port, pin, duty
//   out       out_valid / out_ready   ok, read_duty, timer_number,
//                                     channel_number, has_collision,
//                                     other_port, other_pin,
//                                     port_a_levels, port_b_levels
//   cfg       cfg_valid / cfg_ready   cfg_index, cfg_data
//
// An item is taken into the input register, then applied to the timer state
// as its result is written to the result register; one item per cycle is
// sustained while the output is not stalled. The pin levels are decoded from
// the timer registers, which change only when an item is applied. A stalled
// output holds the input register; in_ready then drops until the result is
// taken. Reset clears all timer state and loads the default prescaler and
// period. cfg_ready is always high.
// ----------------------------------------------------------------------------
module pin_mapped_pwm_timer_bank_unit #(
    parameter int NUM_TIMERS         = ptb_pkg::NUM_TIMERS_DEF,
    parameter int CHANNELS_PER_TIMER = ptb_pkg::CHANNELS_PER_TIMER_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    // Input items
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [2:0]                    opcode,
    input  logic                          port,
    input  logic [ptb_pkg::PIN_W-1:0]     pin,
    input  logic [ptb_pkg::DUTY_W-1:0]    duty,
    // Result items
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic                          ok,
    output logic [ptb_pkg::DUTY_W-1:0]    read_duty,
    output logic [ptb_pkg::TIM_W-1:0]     timer_number,
    output logic [ptb_pkg::CH_W-1:0]      channel_number,
    output logic                          has_collision,
    output logic                          other_port,
    output logic [ptb_pkg::PIN_W-1:0]     other_pin,
    output logic [ptb_pkg::LEVELS_W-1:0]  port_a_levels,
    output logic [ptb_pkg::LEVELS_W-1:0]  port_b_levels,
    // Configuration writes
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [ptb_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [ptb_pkg::DUTY_W-1:0]    cfg_data
);
    import ptb_pkg::*;

    // Input register.
    logic              in_valid_reg;
    logic [2:0]        op_reg;
    logic              port_reg;
    logic [PIN_W-1:0]  pin_reg;
    logic [DUTY_W-1:0] duty_reg;

    // Configuration registers.
    logic [DUTY_W-1:0] prescale_reg;
    logic [DUTY_W-1:0] period_reg;

    // Result register.
    logic              out_valid_reg;
    logic              ok_reg,    ok_next;
    logic [DUTY_W-1:0] rd_reg,    rd_next;
    logic [TIM_W-1:0]  tn_reg,    tn_next;
    logic [CH_W-1:0]   cn_reg,    cn_next;
    logic              hc_reg,    hc_next;
    logic              oport_reg, oport_next;
    logic [PIN_W-1:0]  opin_reg,  opin_next;

    logic              out_free;
    logic              advance;
    map_info_t         info;
    tmr_cmd_t          cmd [NUM_TIMERS];
    logic [DUTY_W-1:0] tmr_preload [NUM_TIMERS][CHANNELS_PER_TIMER];
    logic [CHANNELS_PER_TIMER-1:0] tmr_level [NUM_TIMERS];

    assign out_free  = !out_valid_reg || out_ready;
    assign advance   = in_valid_reg && out_free;
    assign in_ready  = !in_valid_reg || out_free;
    assign cfg_ready = 1'b1;

    // Input register: holds the item until it is applied.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            op_reg   <= opcode;
            port_reg <= port;
            pin_reg  <= pin;
            duty_reg <= duty;
        end
    end

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prescale_reg <= PRESCALE_RESET;
            period_reg   <= PERIOD_RESET;
        end
        else if (cfg_valid)
        begin
            if (cfg_index == CFG_PRESCALE)
            begin
                prescale_reg <= cfg_data;
            end
            if (cfg_index == CFG_PERIOD)
            begin
                period_reg <= cfg_data;
            end
        end
    end

    // Pin decode of the held item.
    ptb_pin_map #(
        .NUM_TIMERS         (NUM_TIMERS),
        .CHANNELS_PER_TIMER (CHANNELS_PER_TIMER)
    ) u_map (
        .port (port_reg),
        .pin  (pin_reg),
        .info (info)
    );

    // Commands to the timers and the result fields.
    always_comb
    begin
        ok_next    = 1'b0;
        rd_next    = '0;
        tn_next    = '0;
        cn_next    = '0;
        hc_next    = 1'b0;
        oport_next = 1'b0;
        opin_next  = '0;

        for (int t = 0; t < NUM_TIMERS; t++)
        begin
            cmd[t]      = '0;
            cmd[t].ch   = info.ch;
            cmd[t].duty = duty_reg;
        end

        unique case (op_reg)
            OP_TICK:
            begin
                ok_next = 1'b1;
                for (int t = 0; t < NUM_TIMERS; t++)
                begin
                    cmd[t].tick = advance;
                end
            end
            OP_START, OP_STOP, OP_SET:
            begin
                ok_next = info.supported;
                for (int t = 0; t < NUM_TIMERS; t++)
                begin
                    if (advance && info.supported && (info.tim == TIM_W'(t + 1)))
                    begin
                        cmd[t].start = (op_reg == OP_START);
                        cmd[t].stop  = (op_reg == OP_STOP);
                        cmd[t].set   = (op_reg == OP_SET);
                    end
                end
            end
            OP_GET:
            begin
                ok_next = info.supported;
                for (int t = 0; t < NUM_TIMERS; t++)
                begin
                    for (int c = 0; c < CHANNELS_PER_TIMER; c++)
                    begin
                        if (info.supported && (info.tim == TIM_W'(t + 1))
                            && (info.ch == CH_W'(c)))
                        begin
                            rd_next = tmr_preload[t][c];
                        end
                    end
                end
            end
            OP_QUERY:
            begin
                ok_next    = info.supported;
                tn_next    = info.tim;
                cn_next    = info.ch;
                hc_next    = info.has_coll;
                oport_next = info.other_port;
                opin_next  = info.other_pin;
            end
            default:
            begin
                ok_next = 1'b0;
            end
        endcase
    end

    // Timer instances.
    for (genvar t = 0; t < NUM_TIMERS; t++)
    begin : g_tmr
        ptb_timer #(
            .CHANNELS_PER_TIMER (CHANNELS_PER_TIMER)
        ) u_timer (
            .clk          (clk),
            .rst_n        (rst_n),
            .cmd          (cmd[t]),
            .prescale_div (prescale_reg),
            .period_top   (period_reg),
            .preload      (tmr_preload[t]),
            .level        (tmr_level[t])
        );
    end

    // Result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            ok_reg    <= ok_next;
            rd_reg    <= rd_next;
            tn_reg    <= tn_next;
            cn_reg    <= cn_next;
            hc_reg    <= hc_next;
            oport_reg <= oport_next;
            opin_reg  <= opin_next;
        end
    end

    // Pin levels from the timer state; the map folds to fixed wiring.
    always_comb
    begin
        pin_entry_t ea;
        pin_entry_t eb;
        port_a_levels = '0;
        port_b_levels = '0;
        for (int p = 0; p < LEVELS_W; p++)
        begin
            ea = pin_entry(1'b0, PIN_W'(p));
            eb = pin_entry(1'b1, PIN_W'(p));
            for (int t = 0; t < NUM_TIMERS; t++)
            begin
                for (int c = 0; c < CHANNELS_PER_TIMER; c++)
                begin
                    if (entry_ok(ea, PIN_W'(p), NUM_TIMERS, CHANNELS_PER_TIMER)
                        && (ea.tim == TIM_W'(t + 1)) && (ea.ch == CH_W'(c)))
                    begin
                        port_a_levels[p] = tmr_level[t][c];
                    end
                    if (entry_ok(eb, PIN_W'(p), NUM_TIMERS, CHANNELS_PER_TIMER)
                        && (eb.tim == TIM_W'(t + 1)) && (eb.ch == CH_W'(c)))
                    begin
                        port_b_levels[p] = tmr_level[t][c];
                    end
                end
            end
        end
    end

    assign out_valid      = out_valid_reg;
    assign ok             = ok_reg;
    assign read_duty      = rd_reg;
    assign timer_number   = tn_reg;
    assign channel_number = cn_reg;
    assign has_collision  = hc_reg;
    assign other_port     = oport_reg;
    assign other_pin      = opin_reg;

endmodule

// ===== verif/ptb_result_checker.sv =====
// ----------------------------------------------------------------------------
// ptb_result_checker
// Watches the item, result and register channels of the PWM timer bank,
// keeps its own model of the timers and compares every result field by field.
// ----------------------------------------------------------------------------
module ptb_result_checker (
    input  logic                          clk,
    input  logic                          rst_n,
    // Input items
    input  logic                          in_valid,
    input  logic                          in_ready,
    input  logic [2:0]                    opcode,
    input  logic                          port,
    input  logic [ptb_pkg::PIN_W-1:0]     pin,
    input  logic [ptb_pkg::DUTY_W-1:0]    duty,
    // Result items
    input  logic                          out_valid,
    input  logic                          out_ready,
    input  logic                          ok,
    input  logic [ptb_pkg::DUTY_W-1:0]    read_duty,
    input  logic [ptb_pkg::TIM_W-1:0]     timer_number,
    input  logic [ptb_pkg::CH_W-1:0]      channel_number,
    input  logic                          has_collision,
    input  logic                          other_port,
    input  logic [ptb_pkg::PIN_W-1:0]     other_pin,
    input  logic [ptb_pkg::LEVELS_W-1:0]  port_a_levels,
    input  logic [ptb_pkg::LEVELS_W-1:0]  port_b_levels,
    // Register writes
    input  logic                          cfg_valid,
    input  logic                          cfg_ready,
    input  logic [ptb_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [ptb_pkg::DUTY_W-1:0]    cfg_data,
    // Status for the testbench top
    output int                            mismatches,
    output int                            outstanding
);

    localparam int NUM_TIMERS = ptb_pkg::NUM_TIMERS_DEF;
    localparam int CHANNELS   = ptb_pkg::CHANNELS_PER_TIMER_DEF;
    localparam int SLOTS      = NUM_TIMERS * CHANNELS;

    // Where a pin lands: timer (0 for none), channel and the pin sharing it.
    typedef struct packed {
        logic [2:0] tim;
        logic [1:0] ch;
        logic       shared;
        logic       partner_port;
        logic [3:0] partner_pin;
    } pin_route_t;

    // One result item as the block should present it.
    typedef struct packed {
        logic        ok;
        logic [7:0]  read_duty;
        logic [2:0]  timer_number;
        logic [1:0]  channel_number;
        logic        has_collision;
        logic        other_port;
        logic [3:0]  other_pin;
        logic [15:0] a_levels;
        logic [15:0] b_levels;
    } pwm_result_t;

    // Model of the timer bank.
    logic [7:0]  divider;
    logic [7:0]  top_count;
    logic [7:0]  preload      [SLOTS];
    logic [7:0]  active       [SLOTS];
    logic        enabled      [SLOTS];
    logic [2:0]  users        [NUM_TIMERS];
    logic [7:0]  cycle_pos    [NUM_TIMERS];
    logic [7:0]  prescale_pos [NUM_TIMERS];

    pwm_result_t expected_q [$];
    pwm_result_t got_res;
    pwm_result_t want_res;
    int          result_count = 0;
    int          fail_count   = 0;

    assign mismatches = fail_count;

    // Fixed pin map. Three channels of timer 2 appear on both ports.
    function automatic pin_route_t route_of(input logic prt, input logic [3:0] pn);
        pin_route_t r;
        r = '0;
        case ({prt, pn})
            5'h01: r = {3'd2, 2'd1, 1'b1, 1'b1, 4'd3};
            5'h02: r = {3'd2, 2'd2, 1'b1, 1'b1, 4'd10};
            5'h03: r = {3'd2, 2'd3, 1'b1, 1'b1, 4'd11};
            5'h06: r = {3'd5, 2'd0, 1'b0, 1'b0, 4'd0};
            5'h07: r = {3'd4, 2'd0, 1'b0, 1'b0, 4'd0};
            5'h09: r = {3'd1, 2'd1, 1'b0, 1'b0, 4'd0};
            5'h0a: r = {3'd1, 2'd2, 1'b0, 1'b0, 4'd0};
            5'h10: r = {3'd3, 2'd2, 1'b0, 1'b0, 4'd0};
            5'h11: r = {3'd3, 2'd3, 1'b0, 1'b0, 4'd0};
            5'h13: r = {3'd2, 2'd1, 1'b1, 1'b0, 4'd1};
            5'h14: r = {3'd3, 2'd0, 1'b0, 1'b0, 4'd0};
            5'h15: r = {3'd3, 2'd1, 1'b0, 1'b0, 4'd0};
            5'h1a: r = {3'd2, 2'd2, 1'b1, 1'b0, 4'd2};
            5'h1b: r = {3'd2, 2'd3, 1'b1, 1'b0, 4'd3};
            default: r = '0;
        endcase
        // Entries naming a timer or channel that is not built count as unmapped.
        if (int'(r.tim) > NUM_TIMERS || int'(r.ch) >= CHANNELS)
            r = '0;
        return r;
    endfunction

    // Output level of every pin of one port from the current timer state.
    function automatic logic [15:0] levels_of(input logic prt);
        logic [15:0] lv;
        pin_route_t  r;
        int          p;
        int          s;
        lv = '0;
        for (p = 0; p < 16; p++) begin
            r = route_of(prt, p[3:0]);
            if (r.tim != 0) begin
                s = (int'(r.tim) - 1) * CHANNELS + int'(r.ch);
                if (enabled[s] && users[r.tim - 1] != 0 && cycle_pos[r.tim - 1] < active[s])
                    lv[p] = 1'b1;
            end
        end
        return lv;
    endfunction

    // One tick: every running timer steps its prescaler and maybe its counter.
    task automatic step_timers();
        int t;
        int c;
        for (t = 0; t < NUM_TIMERS; t++) begin
            if (users[t] != 0) begin
                if (prescale_pos[t] >= divider) begin
                    prescale_pos[t] = '0;
                    if (cycle_pos[t] >= top_count) begin
                        cycle_pos[t] = '0;
                        for (c = 0; c < CHANNELS; c++)
                            active[t * CHANNELS + c] = preload[t * CHANNELS + c];
                    end else begin
                        cycle_pos[t] = cycle_pos[t] + 8'd1;
                    end
                end else begin
                    prescale_pos[t] = prescale_pos[t] + 8'd1;
                end
            end
        end
    endtask

    // Applies one item to the model and works out the result it causes.
    task automatic apply_item(input logic [2:0] op, input logic prt, input logic [3:0] pn,
                              input logic [7:0] dv, output pwm_result_t res);
        pin_route_t r;
        pin_route_t partner;
        int         t;
        int         s;
        res = '0;
        r = route_of(prt, pn);
        t = int'(r.tim);
        s = (t != 0) ? (t - 1) * CHANNELS + int'(r.ch) : 0;
        case (op)
            ptb_pkg::OP_TICK: begin
                step_timers();
                res.ok = 1'b1;
            end
            ptb_pkg::OP_START: begin
                // Start always clears the preload; a user is counted only once.
                if (t != 0) begin
                    res.ok = 1'b1;
                    preload[s] = '0;
                    if (!enabled[s]) begin
                        enabled[s] = 1'b1;
                        users[t - 1] = users[t - 1] + 3'd1;
                    end
                end
            end
            ptb_pkg::OP_STOP: begin
                if (t != 0) begin
                    res.ok = 1'b1;
                    if (enabled[s]) begin
                        enabled[s] = 1'b0;
                        users[t - 1] = users[t - 1] - 3'd1;
                    end
                end
            end
            ptb_pkg::OP_SET: begin
                if (t != 0) begin
                    res.ok = 1'b1;
                    preload[s] = dv;
                end
            end
            ptb_pkg::OP_GET: begin
                if (t != 0) begin
                    res.ok = 1'b1;
                    res.read_duty = preload[s];
                end
            end
            ptb_pkg::OP_QUERY: begin
                if (t != 0) begin
                    res.ok = 1'b1;
                    res.timer_number = r.tim;
                    res.channel_number = r.ch;
                    partner = route_of(r.partner_port, r.partner_pin);
                    if (r.shared && partner.tim != 0) begin
                        res.has_collision = 1'b1;
                        res.other_port = r.partner_port;
                        res.other_pin = r.partner_pin;
                    end
                end
            end
            default: ;
        endcase
        res.a_levels = levels_of(1'b0);
        res.b_levels = levels_of(1'b1);
    endtask

    task automatic clear_model();
        int i;
        divider = ptb_pkg::PRESCALE_RESET;
        top_count = ptb_pkg::PERIOD_RESET;
        for (i = 0; i < SLOTS; i++) begin
            preload[i] = '0;
            active[i] = '0;
            enabled[i] = 1'b0;
        end
        for (i = 0; i < NUM_TIMERS; i++) begin
            users[i] = '0;
            cycle_pos[i] = '0;
            prescale_pos[i] = '0;
        end
    endtask

    task automatic report_mismatch(input string msg);
        $display("MISMATCH at %0t: %s", $realtime, msg);
        fail_count = fail_count + 1;
    endtask

    task automatic check_field(input string name, input logic [15:0] got,
                               input logic [15:0] want);
        if (got !== want)
            report_mismatch($sformatf("result %0d: %s is 0x%0h, expected 0x%0h",
                                      result_count, name, got, want));
    endtask

    // Results are checked before the item of the same edge is predicted.
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            clear_model();
            expected_q.delete();
            outstanding <= 0;
        end else begin
            if (out_valid && out_ready) begin
                result_count = result_count + 1;
                got_res = {ok, read_duty, timer_number, channel_number, has_collision,
                           other_port, other_pin, port_a_levels, port_b_levels};
                if (expected_q.size() == 0) begin
                    report_mismatch($sformatf("result %0d arrived with nothing expected",
                                              result_count));
                end else begin
                    want_res = expected_q.pop_front();
                    check_field("ok", got_res.ok, want_res.ok);
                    check_field("read_duty", got_res.read_duty, want_res.read_duty);
                    check_field("timer_number", got_res.timer_number, want_res.timer_number);
                    check_field("channel_number", got_res.channel_number,
                                want_res.channel_number);
                    check_field("has_collision", got_res.has_collision,
                                want_res.has_collision);
                    check_field("other_port", got_res.other_port, want_res.other_port);
                    check_field("other_pin", got_res.other_pin, want_res.other_pin);
                    check_field("port_a_levels", got_res.a_levels, want_res.a_levels);
                    check_field("port_b_levels", got_res.b_levels, want_res.b_levels);
                end
            end

            // Register writes only happen while the bank is idle.
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    ptb_pkg::CFG_PRESCALE: divider = cfg_data;
                    ptb_pkg::CFG_PERIOD:   top_count = cfg_data;
                    default: ;
                endcase
            end

            if (in_valid && in_ready) begin
                apply_item(opcode, port, pin, duty, want_res);
                expected_q.push_back(want_res);
            end

            outstanding <= expected_q.size();
        end
    end

endmodule

// ===== verif/tb_pin_mapped_pwm_timer_bank_unit.sv =====
// ----------------------------------------------------------------------------
// tb_pin_mapped_pwm_timer_bank_unit
// Drives the PWM timer bank with a directed set of items and several random
// phases under different prescaler and period settings, with random stalls
// on both channels and one long output hold-off. A checker module beside the
// block predicts every result; this module only drives and gives the verdict.
// ----------------------------------------------------------------------------
module tb_pin_mapped_pwm_timer_bank_unit;

    // Spare opcodes that the block must answer without any state change.
    localparam logic [2:0] OP_SPARE_LO = 3'd6;
    localparam logic [2:0] OP_SPARE_HI = 3'd7;

    // Longest stretch without any accepted item before the run is abandoned.
    localparam int QUIET_LIMIT = 2000;
    // Length of the deliberate output hold-off.
    localparam int HOLD_CYCLES = 300;

    // Every pin that has a channel, as {port, pin}.
    localparam logic [14*5-1:0] MAPPED_PINS = {
        5'h01, 5'h02, 5'h03, 5'h06, 5'h07, 5'h09, 5'h0a,
        5'h10, 5'h11, 5'h13, 5'h14, 5'h15, 5'h1a, 5'h1b
    };

    logic                          clk = 1'b0;
    logic                          rst_n;
    logic                          in_valid;
    logic                          in_ready;
    logic [2:0]                    opcode;
    logic                          port;
    logic [ptb_pkg::PIN_W-1:0]     pin;
    logic [ptb_pkg::DUTY_W-1:0]    duty;
    logic                          out_valid;
    logic                          out_ready;
    logic                          ok;
    logic [ptb_pkg::DUTY_W-1:0]    read_duty;
    logic [ptb_pkg::TIM_W-1:0]     timer_number;
    logic [ptb_pkg::CH_W-1:0]      channel_number;
    logic                          has_collision;
    logic                          other_port;
    logic [ptb_pkg::PIN_W-1:0]     other_pin;
    logic [ptb_pkg::LEVELS_W-1:0]  port_a_levels;
    logic [ptb_pkg::LEVELS_W-1:0]  port_b_levels;
    logic                          cfg_valid;
    logic                          cfg_ready;
    logic [ptb_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [ptb_pkg::DUTY_W-1:0]    cfg_data;

    int         errors;
    int         pending;
    int         quiet_cycles = 0;
    logic       gaps_on;
    logic       stalls_on;
    logic       pressure_go;
    logic       pressure_done;
    logic [7:0] cur_top;

    // Clock: period of 10.
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    pin_mapped_pwm_timer_bank_unit dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .opcode         (opcode),
        .port           (port),
        .pin            (pin),
        .duty           (duty),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .ok             (ok),
        .read_duty      (read_duty),
        .timer_number   (timer_number),
        .channel_number (channel_number),
        .has_collision  (has_collision),
        .other_port     (other_port),
        .other_pin      (other_pin),
        .port_a_levels  (port_a_levels),
        .port_b_levels  (port_b_levels),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    ptb_result_checker checker_i (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .opcode         (opcode),
        .port           (port),
        .pin            (pin),
        .duty           (duty),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .ok             (ok),
        .read_duty      (read_duty),
        .timer_number   (timer_number),
        .channel_number (channel_number),
        .has_collision  (has_collision),
        .other_port     (other_port),
        .other_pin      (other_pin),
        .port_a_levels  (port_a_levels),
        .port_b_levels  (port_b_levels),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .mismatches     (errors),
        .outstanding    (pending)
    );

    // Watchdog: ends the run when nothing has been accepted for too long.
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // Result side: random stall bursts, and one long hold-off on request.
    initial
    begin
        out_ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (pressure_go && !pressure_done)
            begin
                out_ready <= 1'b0;
                pressure_done = 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                out_ready <= 1'b1;
            end
            else if (stalls_on && $urandom_range(0, 9) == 0)
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 13)) @(posedge clk);
                out_ready <= 1'b1;
            end
            else
            begin
                out_ready <= 1'b1;
            end
        end
    end

    // Offers one item, after an optional idle burst, and waits until it is taken.
    task automatic send_item(input logic [2:0] op, input logic prt, input logic [3:0] pn,
                             input logic [7:0] dv);
        if (gaps_on && $urandom_range(0, 7) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge clk);
        end
        in_valid <= 1'b1;
        opcode <= op;
        port <= prt;
        pin <= pn;
        duty <= dv;
        do
            @(posedge clk);
        while (!in_ready);
    endtask

    // Writes one register once every result of earlier items has come back.
    task automatic write_reg(input ptb_pkg::cfg_index_t idx, input logic [7:0] value);
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (pending != 0);
        repeat (4) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == ptb_pkg::CFG_PERIOD)
            cur_top = value;
    endtask

    // Mostly pins with a channel, sometimes any pin at all.
    function automatic logic [4:0] pick_location();
        int k;
        k = $urandom_range(0, 13);
        if ($urandom_range(0, 3) == 0)
            return 5'($urandom_range(0, 31));
        return MAPPED_PINS[k * 5 +: 5];
    endfunction

    // Duty values around the period edge are the interesting ones.
    function automatic logic [7:0] pick_duty();
        case ($urandom_range(0, 9))
            0:       return 8'd0;
            1:       return 8'd255;
            2:       return cur_top;
            3:       return cur_top + 8'd1;
            4:       return cur_top - 8'd1;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // Random items; tick_pct sets the share of ticks. The long hold-off of
    // the result side starts after item hold_at when that is not negative.
    task automatic random_phase(input int count, input int tick_pct, input int hold_at);
        int         i;
        int         k;
        logic [2:0] op;
        logic [4:0] loc;
        for (i = 0; i < count; i++)
        begin
            if ($urandom_range(0, 99) < tick_pct)
            begin
                op = ptb_pkg::OP_TICK;
            end
            else
            begin
                k = $urandom_range(0, 99);
                if (k < 24)
                    op = ptb_pkg::OP_START;
                else if (k < 36)
                    op = ptb_pkg::OP_STOP;
                else if (k < 64)
                    op = ptb_pkg::OP_SET;
                else if (k < 78)
                    op = ptb_pkg::OP_GET;
                else if (k < 92)
                    op = ptb_pkg::OP_QUERY;
                else if (k < 96)
                    op = OP_SPARE_LO;
                else
                    op = OP_SPARE_HI;
            end
            loc = pick_location();
            send_item(op, loc[4], loc[3:0], pick_duty());
            if (i == hold_at)
                pressure_go = 1'b1;
        end
    endtask

    // Main sequence.
    initial
    begin
        rst_n <= 1'b0;
        in_valid <= 1'b0;
        opcode <= ptb_pkg::OP_TICK;
        port <= 1'b0;
        pin <= '0;
        duty <= '0;
        cfg_valid <= 1'b0;
        cfg_index <= ptb_pkg::CFG_PRESCALE;
        cfg_data <= '0;
        gaps_on = 1'b0;
        stalls_on = 1'b0;
        pressure_go = 1'b0;
        pressure_done = 1'b0;
        cur_top = ptb_pkg::PERIOD_RESET;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // Map queries: shared channels, a lone channel and unmapped pins.
        send_item(ptb_pkg::OP_QUERY, 1'b0, 4'd1, 8'd0);
        send_item(ptb_pkg::OP_QUERY, 1'b1, 4'd11, 8'd0);
        send_item(ptb_pkg::OP_QUERY, 1'b0, 4'd6, 8'd0);
        send_item(ptb_pkg::OP_QUERY, 1'b1, 4'd15, 8'd255);
        send_item(ptb_pkg::OP_QUERY, 1'b0, 4'd0, 8'd0);
        // Unmapped pins change nothing.
        send_item(ptb_pkg::OP_START, 1'b0, 4'd4, 8'd0);
        send_item(ptb_pkg::OP_SET, 1'b0, 4'd4, 8'd255);
        send_item(ptb_pkg::OP_STOP, 1'b1, 4'd2, 8'd0);
        send_item(ptb_pkg::OP_GET, 1'b0, 4'd15, 8'd0);
        // Stopping a channel that is already off.
        send_item(ptb_pkg::OP_STOP, 1'b1, 4'd4, 8'd0);
        // A second start clears the preload but adds no user.
        send_item(ptb_pkg::OP_START, 1'b0, 4'd9, 8'd0);
        send_item(ptb_pkg::OP_SET, 1'b0, 4'd9, 8'd255);
        send_item(ptb_pkg::OP_GET, 1'b0, 4'd9, 8'd0);
        send_item(ptb_pkg::OP_START, 1'b0, 4'd9, 8'd0);
        send_item(ptb_pkg::OP_GET, 1'b0, 4'd9, 8'd0);
        send_item(ptb_pkg::OP_SET, 1'b0, 4'd9, 8'd200);
        // Two pins on one channel see the same preload.
        send_item(ptb_pkg::OP_START, 1'b1, 4'd3, 8'd0);
        send_item(ptb_pkg::OP_SET, 1'b0, 4'd1, 8'd255);
        send_item(ptb_pkg::OP_GET, 1'b1, 4'd3, 8'd0);
        send_item(ptb_pkg::OP_TICK, 1'b0, 4'd0, 8'd0);
        send_item(ptb_pkg::OP_TICK, 1'b1, 4'd15, 8'd255);
        // Spare opcodes.
        send_item(OP_SPARE_LO, 1'b1, 4'd15, 8'd255);
        send_item(OP_SPARE_HI, 1'b0, 4'd9, 8'd0);
        send_item(ptb_pkg::OP_STOP, 1'b0, 4'd9, 8'd0);
        send_item(ptb_pkg::OP_STOP, 1'b1, 4'd3, 8'd0);

        // Fastest timers: every tick steps, period of two.
        write_reg(ptb_pkg::CFG_PRESCALE, 8'd0);
        write_reg(ptb_pkg::CFG_PERIOD, 8'd1);
        gaps_on = 1'b1;
        stalls_on = 1'b1;
        random_phase(300, 50, -1);

        // Longest period, mostly ticks so that counters get far.
        write_reg(ptb_pkg::CFG_PERIOD, 8'd255);
        gaps_on = 1'($urandom_range(0, 1));
        stalls_on = 1'($urandom_range(0, 1));
        random_phase(400, 70, -1);

        // Slowest prescaler with a short period.
        write_reg(ptb_pkg::CFG_PRESCALE, 8'd255);
        write_reg(ptb_pkg::CFG_PERIOD, 8'd3);
        gaps_on = 1'b0;
        stalls_on = 1'b1;
        random_phase(250, 60, -1);

        // Back-to-back items while the result side holds off.
        write_reg(ptb_pkg::CFG_PRESCALE, 8'd2);
        write_reg(ptb_pkg::CFG_PERIOD, 8'd6);
        gaps_on = 1'b0;
        stalls_on = 1'b0;
        random_phase(300, 50, 40);

        // A random small setting.
        write_reg(ptb_pkg::CFG_PRESCALE, 8'($urandom_range(0, 4)));
        write_reg(ptb_pkg::CFG_PERIOD, 8'($urandom_range(1, 12)));
        gaps_on = 1'b1;
        stalls_on = 1'b1;
        random_phase(350, 55, -1);

        // Last part runs without any idling.
        write_reg(ptb_pkg::CFG_PRESCALE, 8'd1);
        write_reg(ptb_pkg::CFG_PERIOD, 8'd5);
        gaps_on = 1'b0;
        stalls_on = 1'b0;
        random_phase(200, 50, -1);

        // Drain, then wait for any stray result.
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (pending != 0);
        repeat (8) @(posedge clk);

        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
